### rtl/core/rbfe_pkg.sv
`timescale 1ns / 1ps

package rbfe_pkg;

    // ring store geometry
    localparam int DEPTH  = 256;
    localparam int ADDR_W = $clog2(DEPTH);

    // frame layout
    localparam int HDR_SPAN    = 6;
    localparam int FRAME_EXTRA = 7;
    localparam int LEN_W       = 16;
    localparam int TOT_W       = LEN_W + 1;

    typedef logic [ADDR_W-1:0] t_idx;

    // item opcodes
    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POLL = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    // result status codes
    localparam logic [2:0] ST_PUSHED    = 3'd0;
    localparam logic [2:0] ST_DROPPED   = 3'd1;
    localparam logic [2:0] ST_IDLE      = 3'd2;
    localparam logic [2:0] ST_READY     = 3'd3;
    localparam logic [2:0] ST_SKIPPED   = 3'd4;
    localparam logic [2:0] ST_READ      = 3'd5;
    localparam logic [2:0] ST_NOTHING   = 3'd6;

    // configuration register indexes
    localparam logic CFG_HEADER_FIRST  = 1'b0;
    localparam logic CFG_HEADER_SECOND = 1'b1;

    // peek slots
    localparam logic [1:0] PK_HDR0  = 2'd0;
    localparam logic [1:0] PK_HDR1  = 2'd1;
    localparam logic [1:0] PK_LENHI = 2'd2;
    localparam logic [1:0] PK_LENLO = 2'd3;
    localparam int         PK_COUNT = 4;

    // byte offset from the head for each peek slot
    function automatic logic [2:0] peek_offset(input logic [1:0] sel);
        logic [2:0] off;
        case (sel)
            PK_HDR0:  off = 3'd0;
            PK_HDR1:  off = 3'd1;
            PK_LENHI: off = 3'd4;
            PK_LENLO: off = 3'd5;
            default:  off = 3'd0;
        endcase
        return off;
    endfunction

    // index plus small offset, wrapped modulo the depth
    function automatic t_idx wrap_add(input t_idx idx, input logic [2:0] off);
        logic [ADDR_W:0] s;
        s = {1'b0, idx} + (ADDR_W + 1)'(off);
        if (s >= (ADDR_W + 1)'(DEPTH)) begin
            s = s - (ADDR_W + 1)'(DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

    // commands from controller to datapath
    typedef struct packed {
        logic       cap_in;
        logic       push;
        logic       peek_rd;
        logic [1:0] peek_sel;
        logic       peek_cap;
        logic [1:0] cap_sel;
        logic       skip;
        logic       take;
        logic       pop_rd;
        logic       pop_commit;
        logic       pend_clr;
        logic       set_status;
        logic [2:0] status;
        logic       load_out;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        t_op  op;
        logic full;
        logic poll_go;
        logic pop_go;
        logic reject;
        logic complete;
        logic out_free;
    } t_stat;

endpackage

### rtl/core/rbfe_ctrl.sv
`timescale 1ns / 1ps

module rbfe_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  rbfe_pkg::t_stat i_stat,
    output rbfe_pkg::t_cmd  o_cmd
);
    import rbfe_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_PEEK   = 6'b000100,
        S_CHECK  = 6'b001000,
        S_POP    = 6'b010000,
        S_FIN    = 6'b100000
    } t_state;

    t_state     r_state;
    t_state     n_state;
    logic [2:0] r_k;
    logic [2:0] n_k;

    // no item is taken while reset is held
    assign o_in_ready = i_rst_n && (r_state == S_IDLE);

    // state and peek counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= 3'd0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap_in = 1'b1;
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_FIN;
                o_cmd.set_status = 1'b1;
                case (i_stat.op)
                    OP_PUSH: begin
                        if (i_stat.full) begin
                            o_cmd.status = ST_DROPPED;
                        end else begin
                            o_cmd.push   = 1'b1;
                            o_cmd.status = ST_PUSHED;
                        end
                    end
                    OP_POLL: begin
                        if (i_stat.poll_go) begin
                            o_cmd.set_status = 1'b0;
                            n_k              = 3'd0;
                            n_state          = S_PEEK;
                        end else begin
                            o_cmd.status = ST_IDLE;
                        end
                    end
                    OP_READ: begin
                        if (i_stat.pop_go) begin
                            o_cmd.set_status = 1'b0;
                            o_cmd.pop_rd     = 1'b1;
                            n_state          = S_POP;
                        end else begin
                            o_cmd.pend_clr = 1'b1;
                            o_cmd.status   = ST_NOTHING;
                        end
                    end
                    default: begin
                        o_cmd.status = ST_IDLE;
                    end
                endcase
            end
            // one store read per cycle, each captured into its peek slot in the next cycle
            S_PEEK: begin
                o_cmd.peek_rd  = (r_k < 3'(PK_COUNT));
                o_cmd.peek_sel = r_k[1:0];
                o_cmd.peek_cap = (r_k != 3'd0);
                o_cmd.cap_sel  = 2'(r_k - 3'd1);
                if (r_k == 3'(PK_COUNT)) begin
                    n_k     = 3'd0;
                    n_state = S_CHECK;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            S_CHECK: begin
                o_cmd.set_status = 1'b1;
                n_state          = S_FIN;
                if (i_stat.reject) begin
                    o_cmd.skip   = 1'b1;
                    o_cmd.status = ST_SKIPPED;
                end else if (i_stat.complete) begin
                    o_cmd.take   = 1'b1;
                    o_cmd.status = ST_READY;
                end else begin
                    o_cmd.status = ST_IDLE;
                end
            end
            S_POP: begin
                o_cmd.pop_commit = 1'b1;
                o_cmd.set_status = 1'b1;
                o_cmd.status     = ST_READ;
                n_state          = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/rbfe_dpath.sv
`timescale 1ns / 1ps

module rbfe_dpath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_index,
    input  logic [7:0]      i_cfg_data,
    input  logic [1:0]      i_in_opcode,
    input  logic [7:0]      i_in_byte,
    input  rbfe_pkg::t_cmd  i_cmd,
    output rbfe_pkg::t_stat o_stat,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [23:0]     o_out_tdata,
    output logic [2:0]      o_out_tuser,
    output logic            o_out_tlast
);
    import rbfe_pkg::*;

    logic [7:0]  r_hdr_first;
    logic [7:0]  r_hdr_second;
    t_idx        r_rd;
    t_idx        r_wr;
    logic        r_pending;
    t_idx        r_left;
    t_op         r_op;
    logic [7:0]  r_byte;
    logic [7:0]  mem [DEPTH];
    logic [7:0]  r_mem_q;
    logic [7:0]  r_peek [PK_COUNT];
    logic [2:0]  r_res_status;
    logic [7:0]  r_res_byte;
    logic [7:0]  r_res_flen;
    logic        r_res_last;
    logic        r_out_valid;
    logic [23:0] r_out_tdata;
    logic [2:0]  r_out_tuser;
    logic        r_out_tlast;

    t_idx             fill;
    t_idx             rd_addr;
    logic [TOT_W-1:0] total;
    logic             hdr_ok;

    // bytes held, modulo the depth
    always_comb begin
        if (r_wr >= r_rd) begin
            fill = r_wr - r_rd;
        end else begin
            fill = ADDR_W'((ADDR_W + 1)'(r_wr) + (ADDR_W + 1)'(DEPTH) - (ADDR_W + 1)'(r_rd));
        end
    end

    assign total  = TOT_W'({r_peek[PK_LENHI], r_peek[PK_LENLO]}) + TOT_W'(FRAME_EXTRA);
    assign hdr_ok = (r_peek[PK_HDR0] == r_hdr_first) && (r_peek[PK_HDR1] == r_hdr_second);
    assign rd_addr = i_cmd.pop_rd ? r_rd : wrap_add(r_rd, peek_offset(i_cmd.peek_sel));

    // status toward the controller
    always_comb begin
        o_stat.op       = r_op;
        o_stat.full     = (fill == ADDR_W'(DEPTH - 1));
        o_stat.poll_go  = !r_pending && ((ADDR_W + 1)'(fill) >= (ADDR_W + 1)'(HDR_SPAN));
        o_stat.pop_go   = r_pending && (r_left != '0);
        o_stat.reject   = !hdr_ok || (total > TOT_W'(DEPTH - 1));
        o_stat.complete = (TOT_W'(fill) >= total);
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    // header registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_first  <= 8'd170;
            r_hdr_second <= 8'd85;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HEADER_FIRST:  r_hdr_first  <= i_cfg_data;
                CFG_HEADER_SECOND: r_hdr_second <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ring indices and frame tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd      <= '0;
            r_wr      <= '0;
            r_pending <= 1'b0;
            r_left    <= '0;
        end else begin
            if (i_cmd.push) begin
                r_wr <= wrap_add(r_wr, 3'd1);
            end
            if (i_cmd.skip) begin
                r_rd <= wrap_add(r_rd, 3'd1);
            end
            if (i_cmd.take) begin
                r_pending <= 1'b1;
                r_left    <= total[ADDR_W-1:0];
            end
            if (i_cmd.pend_clr) begin
                r_pending <= 1'b0;
            end
            if (i_cmd.pop_commit) begin
                r_rd   <= wrap_add(r_rd, 3'd1);
                r_left <= r_left - t_idx'(1);
                if (r_left == t_idx'(1)) begin
                    r_pending <= 1'b0;
                end
            end
        end
    end

    // byte store, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[r_wr] <= r_byte;
        end
        if (i_cmd.peek_rd || i_cmd.pop_rd) begin
            r_mem_q <= mem[rd_addr];
        end
    end

    // item capture, peek slots and result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_op       <= t_op'(i_in_opcode);
            r_byte     <= i_in_byte;
            r_res_byte <= 8'd0;
            r_res_flen <= 8'd0;
            r_res_last <= 1'b0;
        end
        if (i_cmd.peek_cap) begin
            r_peek[i_cmd.cap_sel] <= r_mem_q;
        end
        if (i_cmd.set_status) begin
            r_res_status <= i_cmd.status;
        end
        if (i_cmd.take) begin
            r_res_flen <= total[7:0];
        end
        if (i_cmd.pop_commit) begin
            r_res_byte <= r_mem_q;
            r_res_last <= (r_left == t_idx'(1));
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_tdata <= {8'(fill), r_res_flen, r_res_byte};
            r_out_tuser <= r_res_status;
            r_out_tlast <= r_res_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_tdata = r_out_tdata;
    assign o_out_tuser = r_out_tuser;
    assign o_out_tlast = r_out_tlast;

endmodule

### rtl/core/ring_buffer_frame_extractor_core.sv
`timescale 1ns / 1ps
// channel   dir  handshake                      payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready tdata: in_byte; tuser: opcode
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready tdata: out_byte, frame_length,
//                                                fill_level; tuser: status;
//                                                tlast: last_byte
// cfg       in   i_cfg_we (no wait)             i_cfg_index, i_cfg_data
//
// one item at a time: push, opcode three, an idle poll or an empty read pass idle,
// decode and finish; a frame byte read adds a pop; a poll that peeks adds four
// store reads and one header check; finish waits while the output stays full
// reset is synchronous, active low, and also holds off the input; the byte
// store has no reset since only held bytes are ever read
// a stalled output holds the finished item; the next item waits for it

module ring_buffer_frame_extractor_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [7:0] out_byte, [15:8] frame_length,
                                          // [23:16] fill_level
    output logic [2:0]  o_m_axis_tuser,   // [2:0] status
    output logic        o_m_axis_tlast
);
    import rbfe_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencing of push, poll and read items
    rbfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // ring store, indices and result registers
    rbfe_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_opcode (i_s_axis_tuser),
        .i_in_byte   (i_s_axis_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_tdata (o_m_axis_tdata),
        .o_out_tuser (o_m_axis_tuser),
        .o_out_tlast (o_m_axis_tlast)
    );

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import rbfe_pkg::*;

    // byte offsets of the big-endian length inside a frame
    localparam int LEN_HI_AT   = 4;
    localparam int LEN_LO_AT   = 5;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int N_DIRECTED  = 29;

    // one result item as seen on the master side
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] data;
        logic [7:0] flen;
        logic       last;
        logic [7:0] fill;
    } t_frame_result;

    // one row of the directed table; want is used only where typed is set
    typedef struct packed {
        t_op           op;
        logic [7:0]    data;
        logic          typed;
        t_frame_result want;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [7:0]  i_cfg_data = 8'h00;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic [1:0]  i_s_axis_tuser = 2'd0;    // [1:0] opcode
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;           // [7:0] out_byte, [15:8] frame_length,
                                           // [23:16] fill_level
    logic [2:0]  o_m_axis_tuser;           // [2:0] status
    logic        o_m_axis_tlast;

    ring_buffer_frame_extractor_core dut (.*);

    always #5 i_clk = ~i_clk;

    // mirror of the deframer state and header registers
    logic [7:0]    store_copy [DEPTH] = '{default: 8'h00};
    int            head_idx = 0;
    int            tail_idx = 0;
    bit            frame_held = 1'b0;
    int            frame_left = 0;
    logic [7:0]    cfg_first = 8'd170;
    logic [7:0]    cfg_second = 8'd85;

    t_frame_result expected_outcomes [$];
    t_frame_result last_outcome;
    bit            sender_quiet = 1'b0;
    bit            hold_request = 1'b0;
    int            items_sent = 0;
    int            results_seen = 0;
    int            mismatches = 0;
    int            frames_found = 0;
    int            frame_ends = 0;
    int            bytes_skipped = 0;
    int            bytes_dropped = 0;
    int            cycle_count = 0;

    t_stim_row directed_rows [N_DIRECTED] = '{
        '{OP_READ, 8'h00, 1'b1, '{ST_NOTHING, 8'h00, 8'h00, 1'b0, 8'd0}},
        '{OP_NONE, 8'hFF, 1'b1, '{ST_IDLE,    8'h00, 8'h00, 1'b0, 8'd0}},
        '{OP_PUSH, 8'hAA, 1'b1, '{ST_PUSHED,  8'h00, 8'h00, 1'b0, 8'd1}},
        '{OP_PUSH, 8'h55, 1'b0, '0},
        '{OP_PUSH, 8'h00, 1'b0, '0},
        '{OP_PUSH, 8'hFF, 1'b0, '0},
        '{OP_PUSH, 8'h00, 1'b0, '0},
        '{OP_PUSH, 8'h00, 1'b0, '0},
        // header fine, frame not yet whole
        '{OP_POLL, 8'h00, 1'b0, '0},
        '{OP_PUSH, 8'hFF, 1'b0, '0},
        // stored behind the frame
        '{OP_PUSH, 8'h5A, 1'b0, '0},
        '{OP_POLL, 8'hFF, 1'b0, '0},
        // poll while a frame waits
        '{OP_POLL, 8'hFF, 1'b0, '0},
        '{OP_READ, 8'hFF, 1'b0, '0},
        '{OP_READ, 8'h00, 1'b0, '0},
        '{OP_READ, 8'hFF, 1'b0, '0},
        '{OP_READ, 8'h00, 1'b0, '0},
        '{OP_READ, 8'hFF, 1'b0, '0},
        '{OP_READ, 8'h00, 1'b0, '0},
        '{OP_READ, 8'hFF, 1'b0, '0},
        '{OP_PUSH, 8'hAA, 1'b0, '0},
        '{OP_PUSH, 8'h55, 1'b0, '0},
        '{OP_PUSH, 8'h00, 1'b0, '0},
        '{OP_PUSH, 8'hFF, 1'b0, '0},
        '{OP_PUSH, 8'h01, 1'b0, '0},
        // stray byte at the head: header mismatch
        '{OP_POLL, 8'h00, 1'b0, '0},
        '{OP_PUSH, 8'h00, 1'b0, '0},
        // length 256 does not fit the store
        '{OP_POLL, 8'h00, 1'b0, '0},
        // fewer than six bytes held
        '{OP_POLL, 8'hFF, 1'b0, '0}
    };

    function automatic int held_bytes();
        return (tail_idx + DEPTH - head_idx) % DEPTH;
    endfunction

    function automatic logic [7:0] byte_at_head(input int k);
        return store_copy[(head_idx + k) % DEPTH];
    endfunction

    // expected result of one item, updating the mirror state
    function automatic t_frame_result advance_deframer(input t_op op, input logic [7:0] b);
        t_frame_result res;
        int            fill;
        int            len;
        int            total;
        bit            hdr_ok;
        res = '0;
        res.status = ST_IDLE;
        case (op)
            OP_PUSH: begin
                if (held_bytes() >= DEPTH - 1) begin
                    res.status = ST_DROPPED;
                end else begin
                    store_copy[tail_idx] = b;
                    tail_idx = (tail_idx + 1) % DEPTH;
                    res.status = ST_PUSHED;
                end
            end
            OP_POLL: begin
                fill = held_bytes();
                if (!frame_held && fill >= HDR_SPAN) begin
                    len = {byte_at_head(LEN_HI_AT), byte_at_head(LEN_LO_AT)};
                    total = len + FRAME_EXTRA;
                    hdr_ok = byte_at_head(0) == cfg_first && byte_at_head(1) == cfg_second;
                    if (!hdr_ok || total > DEPTH - 1) begin
                        head_idx = (head_idx + 1) % DEPTH;
                        res.status = ST_SKIPPED;
                    end else if (fill >= total) begin
                        frame_held = 1'b1;
                        frame_left = total;
                        res.flen = 8'(total);
                        res.status = ST_READY;
                    end
                end
            end
            OP_READ: begin
                if (!frame_held || frame_left == 0) begin
                    frame_held = 1'b0;
                    res.status = ST_NOTHING;
                end else begin
                    res.data = store_copy[head_idx];
                    store_copy[head_idx] = 8'h00;
                    head_idx = (head_idx + 1) % DEPTH;
                    frame_left--;
                    if (frame_left == 0) begin
                        frame_held = 1'b0;
                        res.last = 1'b1;
                    end
                    res.status = ST_READ;
                end
            end
            default: ;
        endcase
        res.fill = 8'(held_bytes());
        return res;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int gap_len(input bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one item, wait for the handshake, then record its expected result
    task automatic send_item(input t_op op, input logic [7:0] b,
                             input bit typed = 1'b0, input t_frame_result want = '0);
        int gap;
        gap = gap_len(sender_quiet);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        last_outcome = advance_deframer(op, b);
        expected_outcomes.push_back(typed ? want : last_outcome);
        if (op != OP_NONE) items_sent++;
    endtask

    // header, two free bytes, big-endian length, body; stray polls in between
    task automatic send_frame(input logic [7:0] h0, input logic [7:0] h1,
                              input logic [15:0] len, input int body);
        logic [7:0] frame_bytes [$];
        int         k;
        frame_bytes = '{h0, h1, 8'($urandom), 8'($urandom), len[15:8], len[7:0]};
        repeat (body) frame_bytes.push_back(8'($urandom));
        for (k = 0; k < frame_bytes.size(); k++) begin
            if ($urandom_range(0, 19) == 0) send_item(OP_POLL, 8'($urandom));
            send_item(OP_PUSH, frame_bytes[k]);
        end
    endtask

    // poll and read until fewer than six bytes are left and nothing waits
    task automatic settle();
        int guard;
        for (guard = 0; guard < 2000; guard++) begin
            if (frame_held) begin
                repeat (frame_left) send_item(OP_READ, 8'($urandom));
                if ($urandom_range(0, 3) == 0) send_item(OP_READ, 8'($urandom));
            end else if (held_bytes() >= HDR_SPAN) begin
                send_item(OP_POLL, 8'($urandom));
                // incomplete frame: feed it
                if (last_outcome.status == ST_IDLE) send_item(OP_PUSH, 8'($urandom));
            end else begin
                break;
            end
        end
    endtask

    // mostly well-formed frames, plus broken frames and loose items
    task automatic run_random(input int count);
        int         target;
        int         r;
        int         len;
        logic [7:0] h0;
        logic [7:0] h1;
        target = items_sent + count;
        while (items_sent < target) begin
            sender_quiet = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 9);
            if (r < 62) begin
                send_frame(cfg_first, cfg_second, 16'(len), len + 1);
            end else if (r < 72) begin
                h0 = cfg_first;
                h1 = cfg_second;
                if ($urandom_range(0, 1) == 0) h0[$urandom_range(0, 7)] ^= 1'b1;
                else h1[$urandom_range(0, 7)] ^= 1'b1;
                send_frame(h0, h1, 16'(len), len + 1);
            end else if (r < 80) begin
                // length too large for the store
                if ($urandom_range(0, 2) == 0) len = $urandom_range(249, 255);
                else len = {8'($urandom_range(1, 255)), 8'($urandom)};
                send_frame(cfg_first, cfg_second, 16'(len), $urandom_range(0, 3));
            end else begin
                repeat ($urandom_range(1, 6)) send_item(t_op'($urandom_range(0, 3)),
                                                         8'($urandom));
            end
            if ($urandom_range(0, 9) < 7) settle();
        end
        sender_quiet = 1'b0;
    endtask

    // stop offering, let every result come back, then let the clock run on idle
    task automatic wait_for_idle();
        i_s_axis_tvalid <= 1'b0;
        while (expected_outcomes.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_headers(input logic [7:0] first, input logic [7:0] second);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_HEADER_FIRST;
        i_cfg_data  <= first;
        @(posedge i_clk);
        i_cfg_index <= CFG_HEADER_SECOND;
        i_cfg_data  <= second;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_first  = first;
        cfg_second = second;
    endtask

    // stimulus sequence
    initial begin : stimulus
        int i;
        int errors;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < N_DIRECTED; i++) begin
            send_item(directed_rows[i].op, directed_rows[i].data,
                      directed_rows[i].typed, directed_rows[i].want);
        end

        wait_for_idle();
        write_headers(8'h00, 8'hFF);
        run_random(40);
        wait_for_idle();
        write_headers(8'hFF, 8'h00);
        run_random(40);
        wait_for_idle();
        write_headers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        run_random(40);

        // longest frame fills the store, later pushes are dropped; the
        // receiver holds off meanwhile
        settle();
        hold_request = 1'b1;
        send_frame(cfg_first, cfg_second, 16'd248, 249);
        repeat (3) send_item(OP_PUSH, 8'($urandom));

        wait_for_idle();
        errors = mismatches + expected_outcomes.size();
        $display("run: %0d items over four header settings, %0d results checked",
                 items_sent, results_seen);
        $display("run: %0d frames found, %0d ends flagged, %0d skips, %0d drops on full store",
                 frames_found, frame_ends, bytes_skipped, bytes_dropped);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // receiver: random ready pattern with one long hold-off
    initial begin : result_sink
        int run;
        int stall;
        bit hold_done;
        hold_done = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!hold_done && hold_request) begin
                hold_done = 1'b1;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            run = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 10);
            i_m_axis_tready <= 1'b1;
            repeat (run) @(posedge i_clk);
            stall = gap_len($urandom_range(0, 4) == 0);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // compare each result item with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_frame_result seen;
        t_frame_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            seen.status = o_m_axis_tuser;
            seen.data   = o_m_axis_tdata[7:0];
            seen.flen   = o_m_axis_tdata[15:8];
            seen.last   = o_m_axis_tlast;
            seen.fill   = o_m_axis_tdata[23:16];
            results_seen++;
            case (seen.status)
                ST_READY:   frames_found++;
                ST_SKIPPED: bytes_skipped++;
                ST_DROPPED: bytes_dropped++;
                default: ;
            endcase
            if (seen.last === 1'b1) frame_ends++;
            if (expected_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d arrived with nothing expected: status %0d",
                             results_seen, seen.status);
                end
            end else begin
                want = expected_outcomes.pop_front();
                if (seen.status !== want.status || seen.data !== want.data ||
                    seen.flen !== want.flen || seen.last !== want.last ||
                    seen.fill !== want.fill) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display({"result %0d: want st %0d byte %02h len %0d last %0d ",
                                  "fill %0d, got st %0d byte %02h len %0d last %0d fill %0d"},
                                 results_seen, want.status, want.data, want.flen,
                                 want.last, want.fill, seen.status, seen.data,
                                 seen.flen, seen.last, seen.fill);
                    end
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule

### filelist.f
rtl/core/rbfe_pkg.sv
rtl/core/rbfe_ctrl.sv
rtl/core/rbfe_dpath.sv
rtl/core/ring_buffer_frame_extractor_core.sv
verif/testbench.sv
